@@ rtl/tpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants for the timer slot table
// Beat layouts, mode and status codes, sequencer states.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 16;

  localparam int DUE_W  = TIME_BITS + 1;
  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  // item modes
  localparam logic [2:0] MODE_ADD_TMO  = 3'd0;
  localparam logic [2:0] MODE_ADD_PER  = 3'd1;
  localparam logic [2:0] MODE_CANCEL   = 3'd2;
  localparam logic [2:0] MODE_POLL     = 3'd3;
  localparam logic [2:0] MODE_NEXT_DUE = 3'd4;

  // result status
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_ZERO_PER = 3'd2;
  localparam logic [2:0] STAT_NONE     = 3'd3;
  localparam logic [2:0] STAT_UNUSED   = 3'd4;

  typedef struct packed {
    logic [2:0]           mode;
    logic [TIME_BITS-1:0] now_seconds;
    logic [30:0]          interval;
    logic [3:0]           slot;
    logic [15:0]          tag;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  result_slot;
    logic [15:0] result_tag;
    logic        fired;
    logic        timer_kind;
    logic [32:0] due_time;
    logic        last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CANCEL,
    ST_POLL,
    ST_NEXT,
    ST_FLUSH
  } state_t;

endpackage

@@ rtl/timeout_periodic_timer_table_core.sv @@
// ----------------------------------------------------------------------------
// timeout_periodic_timer_table_core: timer slot table with scan sequencer
// Holds one-shot and periodic timers; add, cancel, poll and next-due items.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one item per beat (mode, now, interval, slot, tag). in_ready is
//    high only while the sequencer is idle; one item is worked at a time.
//  - out_*: result beats, valid/ready. Poll gives one beat per fired timer
//    (up to 16, slot order) or a single "nothing due" beat; every other
//    mode gives one beat; unknown modes give none. last marks the final one.
//  - Sequencing: a sequencer walks the slots with one index, one adder and one
//    comparator. Add scans to the first free slot, cancel reads only the
//    given slot, poll and next-due scan all 16 slots. An item is accepted in
//    the idle state, and the final beat is handed to the output register
//    from the flush state.
//  - A poll holds one fired result back until it knows whether another
//    follows, so it can set last; a stalled receiver stalls the scan.
//  - Reset (rst_n low, synchronous) clears all used flags, the sequencer
//    and the output valid flag. Other slot fields are written by add.
// ----------------------------------------------------------------------------
module timeout_periodic_timer_table_core
  import tpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // slot storage
  logic                 use_r [NUM_SLOTS];
  logic                 kind_r [NUM_SLOTS];
  logic [DUE_W-1:0]     due_r [NUM_SLOTS];
  logic [30:0]          per_r [NUM_SLOTS];
  logic [15:0]          tag_r [NUM_SLOTS];

  // sequencer
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [30:0]          ival_r, ival_nxt;
  logic [15:0]          itag_r, itag_nxt;
  logic                 iper_r, iper_nxt;

  // held result and next-due best candidate
  out_beat_t            pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic                 best_v_r, best_v_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [DUE_W-1:0]     best_due_r, best_due_nxt;
  logic [15:0]          best_tag_r, best_tag_nxt;
  logic                 best_kind_r, best_kind_nxt;

  // output register
  out_beat_t            out_r, out_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 out_free;

  // slot write strobes
  logic                 add_wr, use_clr, due_wr;

  // shared datapath
  logic                 rd_use, rd_kind;
  logic [DUE_W-1:0]     rd_due;
  logic [30:0]          rd_per;
  logic [15:0]          rd_tag;
  logic [30:0]          add_b;
  logic [DUE_W-1:0]     sum;
  logic [DUE_W-1:0]     cmp_a, cmp_b;
  logic                 cmp_lt;
  logic                 hit, take, scan_end;

  function automatic out_beat_t mk_res(input logic [2:0] st, input logic [3:0] sl,
                                       input logic [15:0] tg, input logic fi,
                                       input logic kd, input logic [32:0] du,
                                       input logic la);
    out_beat_t r;
    r.status      = st;
    r.result_slot = sl;
    r.result_tag  = tg;
    r.fired       = fi;
    r.timer_kind  = kd;
    r.due_time    = du;
    r.last        = la;
    return r;
  endfunction

  assign rd_use  = use_r[idx_r];
  assign rd_kind = kind_r[idx_r];
  assign rd_due  = due_r[idx_r];
  assign rd_per  = per_r[idx_r];
  assign rd_tag  = tag_r[idx_r];

  // one adder: now + interval on add, now + period on reschedule
  assign add_b = (state_r == ST_ADD) ? ival_r : rd_per;
  assign sum   = DUE_W'(now_r) + DUE_W'(add_b);

  // one comparator: now < due on poll, due < best on next-due
  assign cmp_a  = (state_r == ST_POLL) ? DUE_W'(now_r) : rd_due;
  assign cmp_b  = (state_r == ST_POLL) ? rd_due : best_due_r;
  assign cmp_lt = cmp_a < cmp_b;

  assign hit      = rd_use && !cmp_lt;
  assign take     = rd_use && (!best_v_r || cmp_lt);
  assign scan_end = (idx_r == LAST_IDX);

  assign out_free  = !out_v_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    now_nxt       = now_r;
    ival_nxt      = ival_r;
    itag_nxt      = itag_r;
    iper_nxt      = iper_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    best_v_nxt    = best_v_r;
    best_idx_nxt  = best_idx_r;
    best_due_nxt  = best_due_r;
    best_tag_nxt  = best_tag_r;
    best_kind_nxt = best_kind_r;
    out_nxt       = out_r;
    out_v_nxt     = out_ready ? 1'b0 : out_v_r;
    add_wr        = 1'b0;
    use_clr       = 1'b0;
    due_wr        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt    = in_data.now_seconds;
          ival_nxt   = in_data.interval;
          itag_nxt   = in_data.tag;
          iper_nxt   = (in_data.mode == MODE_ADD_PER);
          idx_nxt    = '0;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          best_v_nxt = 1'b0;
          unique case (in_data.mode) inside
            MODE_ADD_TMO, MODE_ADD_PER: begin
              if (in_data.mode == MODE_ADD_PER && in_data.interval == '0) begin
                pend_nxt  = mk_res(STAT_ZERO_PER, '0, '0, 1'b0, 1'b0, '0, 1'b1);
                state_nxt = ST_FLUSH;
              end else begin
                state_nxt = ST_ADD;
              end
            end
            MODE_CANCEL: begin
              if (32'(in_data.slot) < 32'(NUM_SLOTS)) begin
                idx_nxt   = IDX_W'(in_data.slot);
                state_nxt = ST_CANCEL;
              end else begin
                pend_nxt  = mk_res(STAT_UNUSED, in_data.slot, '0, 1'b0, 1'b0, '0, 1'b1);
                state_nxt = ST_FLUSH;
              end
            end
            MODE_POLL:     state_nxt = ST_POLL;
            MODE_NEXT_DUE: state_nxt = ST_NEXT;
            default:       state_nxt = ST_IDLE;  // unknown mode: dropped
          endcase
        end
      end

      ST_ADD: begin
        if (!rd_use) begin
          add_wr    = 1'b1;
          pend_nxt  = mk_res(STAT_OK, 4'(idx_r), itag_r, 1'b0, iper_r, 33'(sum), 1'b1);
          state_nxt = ST_FLUSH;
        end else if (scan_end) begin
          pend_nxt  = mk_res(STAT_FULL, '0, '0, 1'b0, 1'b0, '0, 1'b1);
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_CANCEL: begin
        if (rd_use) begin
          use_clr  = 1'b1;
          pend_nxt = mk_res(STAT_OK, 4'(idx_r), rd_tag, 1'b0, rd_kind, 33'(rd_due), 1'b1);
        end else begin
          pend_nxt = mk_res(STAT_UNUSED, 4'(idx_r), '0, 1'b0, 1'b0, '0, 1'b1);
        end
        state_nxt = ST_FLUSH;
      end

      ST_POLL: begin
        if (hit) begin
          // held fire result goes out only once the next one is known
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_nxt   = pend_r;
              out_v_nxt = 1'b1;
            end
            if (rd_kind) due_wr = 1'b1;
            else         use_clr = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
            pend_v_nxt = 1'b1;
            pend_nxt   = mk_res(STAT_OK, 4'(idx_r), rd_tag, 1'b1, rd_kind, 33'(rd_due),
                                scan_end || (cnt_r == CNT_W'(MAX_RESULTS - 1)));
            if (scan_end || (cnt_r == CNT_W'(MAX_RESULTS - 1))) state_nxt = ST_FLUSH;
            else                                                 idx_nxt = idx_r + 1'b1;
          end
        end else if (scan_end) begin
          if (pend_v_r) pend_nxt.last = 1'b1;
          else pend_nxt = mk_res(STAT_NONE, '0, '0, 1'b0, 1'b0, '0, 1'b1);
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_NEXT: begin
        if (take) begin
          best_v_nxt    = 1'b1;
          best_idx_nxt  = idx_r;
          best_due_nxt  = rd_due;
          best_tag_nxt  = rd_tag;
          best_kind_nxt = rd_kind;
        end
        if (scan_end) begin
          if (take)
            pend_nxt = mk_res(STAT_OK, 4'(idx_r), rd_tag, 1'b0, rd_kind, 33'(rd_due), 1'b1);
          else if (best_v_r)
            pend_nxt = mk_res(STAT_OK, 4'(best_idx_r), best_tag_r, 1'b0, best_kind_r,
                              33'(best_due_r), 1'b1);
          else
            pend_nxt = mk_res(STAT_NONE, '0, '0, 1'b0, 1'b0, '0, 1'b1);
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_nxt    = pend_r;
          out_v_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      best_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
      best_v_r <= best_v_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    now_r       <= now_nxt;
    ival_r      <= ival_nxt;
    itag_r      <= itag_nxt;
    iper_r      <= iper_nxt;
    pend_r      <= pend_nxt;
    best_idx_r  <= best_idx_nxt;
    best_due_r  <= best_due_nxt;
    best_tag_r  <= best_tag_nxt;
    best_kind_r <= best_kind_nxt;
    out_r       <= out_nxt;
  end

  // used flags: cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) use_r[i] <= 1'b0;
    end else if (add_wr) begin
      use_r[idx_r] <= 1'b1;
    end else if (use_clr) begin
      use_r[idx_r] <= 1'b0;
    end
  end

  // slot fields: written by add, due rewritten on periodic fire
  always_ff @(posedge clk) begin
    if (add_wr) begin
      kind_r[idx_r] <= iper_r;
      per_r[idx_r]  <= ival_r;
      tag_r[idx_r]  <= itag_r;
    end
    if (add_wr || due_wr) begin
      due_r[idx_r] <= sum;
    end
  end

endmodule
